@@ rtl/rau_pkg.sv @@
// Package for the rational arithmetic unit: widths, operation codes, FSM state type
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int OPW  = 16;
    localparam int PW   = 2 * OPW;
    localparam int NW   = PW + 1;
    localparam int DW   = PW;
    localparam int RNW  = 33;
    localparam int RDW  = 32;
    localparam int CW   = $clog2(NW + 1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic div_sel_den;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic gcd_zero;
        logic div_done;
    } stat_t;
endpackage

@@ rtl/rau_ctrl.sv @@
// Controller state machine of the rational arithmetic unit.
// Depends on rau_pkg for the state type and command/status structs.
`timescale 1ns / 1ps
module rau_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          out_valid,
    input  logic          out_ready,
    input  rau_pkg::stat_t st,
    output rau_pkg::cmd_t  cmd
);
    import rau_pkg::*;

    state_t state_reg, state_next;
    logic   out_free;

    assign out_free = !out_valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_GCD;
            ST_GCD:
            begin
                if (st.gcd_zero) state_next = ST_OUT;
                else if (st.gcd_done) state_next = ST_DIVN;
            end
            ST_DIVN: if (st.div_done) state_next = ST_DIVD;
            ST_DIVD: if (st.div_done) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL: cmd.mul = 1'b1;
            ST_SUM: cmd.sum = 1'b1;
            ST_GCD:
            begin
                cmd.gcd_step = !st.gcd_done && !st.gcd_zero;
                cmd.div_start = st.gcd_done;
            end
            ST_DIVN:
            begin
                cmd.div_step = !st.div_done;
                cmd.div_start = st.div_done;
                cmd.div_sel_den = st.div_done;
            end
            ST_DIVD:
            begin
                cmd.div_sel_den = 1'b1;
                cmd.div_step = !st.div_done;
            end
            ST_OUT: cmd.out_load = out_free;
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == ST_IDLE)
        else $error("output load did not return to idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVD && st.div_done) |=> state_reg == ST_OUT)
        else $error("division end lost");
endmodule

@@ rtl/rau_dp.sv @@
// Datapath of the rational arithmetic unit: operand registers, three 16x16 multipliers,
// a binary GCD unit and a shared restoring divider. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rau_pkg::cmd_t              cmd,
    output rau_pkg::stat_t             st,
    input  logic [1:0]                 op,
    input  logic signed [rau_pkg::OPW-1:0] a_num,
    input  logic signed [rau_pkg::OPW-1:0] a_den,
    input  logic signed [rau_pkg::OPW-1:0] b_num,
    input  logic signed [rau_pkg::OPW-1:0] b_den,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [rau_pkg::RNW-1:0] res_num,
    output logic signed [rau_pkg::RDW-1:0] res_den
);
    import rau_pkg::*;

    op_t op_reg;
    logic signed [OPW-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0]  p0_reg, p1_reg, dn_reg;
    logic [NW-1:0] nmag_reg, u_reg, v_reg, q_reg, r_reg, dv_reg;
    logic [DW-1:0] dmag_reg;
    logic          nneg_reg, dneg_reg;
    logic [CW-1:0] sh_reg, cnt_reg;
    logic          gcd_fin, div_fin;
    logic signed [RNW-1:0] res_num_reg;
    logic signed [RDW-1:0] res_den_reg;
    logic          out_valid_reg;

    logic signed [PW-1:0] m0, m1, m2;
    logic signed [PW+1:0] sumx;
    logic [NW-1:0] u_nx, v_nx, lesser, big, diff;
    logic [NW:0]   rtrial;
    logic [NW-1:0] gval, num_q, den_q;

    always_comb
    begin
        m0 = an_reg * ((op_reg == OP_MUL) ? bn_reg : bd_reg);
        m1 = ad_reg * ((op_reg == OP_DIV) ? bn_reg : bd_reg);
        m2 = bn_reg * ad_reg;
        if (op_reg == OP_SUB)
            sumx = {{2{p0_reg[PW-1]}}, p0_reg} - {{2{p1_reg[PW-1]}}, p1_reg};
        else
            sumx = {{2{p0_reg[PW-1]}}, p0_reg} + {{2{p1_reg[PW-1]}}, p1_reg};
    end

    // Binary GCD: strip common twos, halve a lone even value, else subtract the smaller from the larger.
    always_comb
    begin
        lesser = (u_reg < v_reg) ? u_reg : v_reg;
        big    = (u_reg < v_reg) ? v_reg : u_reg;
        diff   = big - lesser;
        u_nx   = u_reg;
        v_nx   = v_reg;
        if (!u_reg[0] && !v_reg[0])
        begin
            u_nx = u_reg >> 1;
            v_nx = v_reg >> 1;
        end
        else if (!u_reg[0])
            u_nx = u_reg >> 1;
        else if (!v_reg[0])
            v_nx = v_reg >> 1;
        else
        begin
            u_nx = lesser;
            v_nx = diff;
        end
        // One of the two is zero at the end, so the other is the odd part.
        gval = (u_reg | v_reg) << sh_reg;
    end

    assign rtrial = {r_reg, q_reg[NW-1]} - {1'b0, dv_reg};
    assign num_q  = nneg_reg ? (~nmag_reg + 1'b1) : nmag_reg;
    assign den_q  = dneg_reg ? (~{1'b0, dmag_reg} + 1'b1) : {1'b0, dmag_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op_t'(op);
            an_reg <= a_num;
            ad_reg <= a_den;
            bn_reg <= b_num;
            bd_reg <= b_den;
        end
        if (cmd.mul)
        begin
            p0_reg <= m0;
            p1_reg <= m2;
            dn_reg <= m1;
        end
        if (cmd.sum)
        begin
            if (op_reg == OP_ADD || op_reg == OP_SUB)
            begin
                nneg_reg <= sumx[PW+1];
                nmag_reg <= sumx[PW+1] ? NW'(-sumx) : NW'(sumx);
            end
            else
            begin
                nneg_reg <= p0_reg[PW-1];
                nmag_reg <= p0_reg[PW-1] ? NW'(-{p0_reg[PW-1], p0_reg})
                                         : NW'({p0_reg[PW-1], p0_reg});
            end
            dneg_reg <= dn_reg[PW-1];
            dmag_reg <= dn_reg[PW-1] ? DW'(-dn_reg) : DW'(dn_reg);
            u_reg <= (op_reg == OP_ADD || op_reg == OP_SUB)
                     ? (sumx[PW+1] ? NW'(-sumx) : NW'(sumx))
                     : (p0_reg[PW-1] ? NW'(-{p0_reg[PW-1], p0_reg})
                                     : NW'({p0_reg[PW-1], p0_reg}));
            v_reg <= {1'b0, (dn_reg[PW-1] ? DW'(-dn_reg) : DW'(dn_reg))};
            sh_reg <= '0;
        end
        if (cmd.gcd_step)
        begin
            u_reg <= u_nx;
            v_reg <= v_nx;
            if (!u_reg[0] && !v_reg[0])
                sh_reg <= sh_reg + 1'b1;
        end
        if (cmd.div_start)
        begin
            q_reg   <= cmd.div_sel_den ? {1'b0, dmag_reg} : nmag_reg;
            r_reg   <= '0;
            cnt_reg <= '0;
            if (!cmd.div_sel_den)
                dv_reg <= gval;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (!rtrial[NW])
            begin
                r_reg <= rtrial[NW-1:0];
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[NW-2:0], q_reg[NW-1]};
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
        if (cmd.div_sel_den && cmd.div_start)
            nmag_reg <= q_reg;
        if (cmd.div_sel_den && !cmd.div_start && div_fin)
            dmag_reg <= q_reg[DW-1:0];
        if (cmd.out_load)
        begin
            res_num_reg <= RNW'(num_q);
            res_den_reg <= RDW'(den_q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        gcd_fin = (u_reg == '0) || (v_reg == '0);
        div_fin = (cnt_reg == CW'(NW));
    end

    // A zero operand makes the other one the GCD.
    always_comb
    begin
        st.gcd_zero = (nmag_reg == '0) && (dmag_reg == '0);
        st.gcd_done = gcd_fin && !st.gcd_zero;
        st.div_done = div_fin;
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gcd_step |-> (u_reg != '0 && v_reg != '0))
        else $error("GCD step with a zero operand");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> dv_reg != '0)
        else $error("division by zero GCD");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(res_num) && $stable(res_den))
        else $error("result changed while stalled");
endmodule

@@ rtl/rational_arith_unit.sv @@
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl and rau_dp.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) takes op and two fractions a_num/a_den,
//   b_num/b_den. Output channel (out_valid/out_ready) returns the reduced
//   fraction res_num/res_den, signs as the cross products left them.
//   One item is worked on at a time. Steps for each item: accept,
//     multiply, sum/magnitude, binary GCD steps, two restoring
//     divisions by the GCD (skipped for 0/0), output load.
//   The binary GCD loop and the one shared bit-serial divider take
//   most of the time of an item.
//   The next item is taken when the result has moved into the output
//   register, so one finished result may wait while the next item computes.
//   When the receiver stalls, the result holds until taken and a further
//   result waits in the datapath.
//   Reset clears the controller to idle and drops out_valid.
module rational_arith_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     op,
    input  logic signed [rau_pkg::OPW-1:0] a_num,
    input  logic signed [rau_pkg::OPW-1:0] a_den,
    input  logic signed [rau_pkg::OPW-1:0] b_num,
    input  logic signed [rau_pkg::OPW-1:0] b_den,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [rau_pkg::RNW-1:0] res_num,
    output logic signed [rau_pkg::RDW-1:0] res_den
);
    import rau_pkg::*;

    cmd_t  cmd;
    stat_t st;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    rau_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .op        (op),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_num   (res_num),
        .res_den   (res_den)
    );
endmodule

@@ verif/rational_arith_unit_test.sv @@
// Testbench for rational_arith_unit: drives fraction pairs and operations, predicts the
// reduced result in-line and checks every output item. Depends on rau_pkg and the RTL.
`timescale 1ns / 1ps
module rational_arith_unit_test;
    import rau_pkg::*;

    typedef struct {
        op_t               op;
        logic signed [15:0] a_num;
        logic signed [15:0] a_den;
        logic signed [15:0] b_num;
        logic signed [15:0] b_den;
    } frac_item_t;

    typedef struct {
        logic signed [32:0] num;
        logic signed [31:0] den;
    } frac_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] op = '0;
    logic signed [15:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [32:0] res_num;
    logic signed [31:0] res_den;

    frac_item_t pending_items[$];
    frac_res_t  expected_fracs[$];
    int errors = 0;
    int checked = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit stim_done = 0;
    logic in_ready_seen = 1'b0;

    rational_arith_unit u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .op(op),
        .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .out_valid(out_valid), .out_ready(out_ready), .res_num(res_num), .res_den(res_den)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Exact signed arithmetic in 64 bits, then reduction of the magnitudes.
    function automatic frac_res_t reduce_fraction(frac_item_t it);
        longint n, d, an, ad, bn, bd;
        longint unsigned g, nm, dm;
        frac_res_t r;
        an = it.a_num; ad = it.a_den; bn = it.b_num; bd = it.b_den;
        case (it.op)
            OP_ADD:  begin n = an * bd + bn * ad; d = ad * bd; end
            OP_SUB:  begin n = an * bd - bn * ad; d = ad * bd; end
            OP_MUL:  begin n = an * bn; d = ad * bd; end
            default: begin n = an * bd; d = ad * bn; end
        endcase
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        g = gcd_of(nm, dm);
        if (g != 0)
        begin
            nm = nm / g;
            dm = dm / g;
        end
        n = (n < 0) ? -longint'(nm) : longint'(nm);
        d = (d < 0) ? -longint'(dm) : longint'(dm);
        r.num = n[32:0];
        r.den = d[31:0];
        return r;
    endfunction

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 4)) - 16'd2;
            3: return 16'($urandom_range(0, 40)) * (($urandom_range(0, 1) != 0) ? 16'd1 : -16'd1);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_item(op_t o, logic [15:0] an, logic [15:0] ad,
                            logic [15:0] bn, logic [15:0] bd);
        frac_item_t it;
        it.op = o; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
        pending_items.push_back(it);
    endtask

    // Driver: presents items at the falling edge and holds them until accepted.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready_seen)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    frac_item_t it;
                    it = pending_items.pop_front();
                    expected_fracs.push_back(reduce_fraction(it));
                    op <= it.op; a_num <= it.a_num; a_den <= it.a_den;
                    b_num <= it.b_num; b_den <= it.b_den;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
        in_ready_seen <= in_valid && in_ready;

    // Monitor: compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_fracs.size() == 0)
            begin
                $display("%t unexpected result %0d/%0d", $time, res_num, res_den);
                errors++;
            end
            else
            begin
                frac_res_t e;
                e = expected_fracs.pop_front();
                checked++;
                if (res_num !== e.num)
                begin
                    $display("%t res_num expected %0d actual %0d", $time, e.num, res_num);
                    errors++;
                end
                if (res_den !== e.den)
                begin
                    $display("%t res_den expected %0d actual %0d", $time, e.den, res_den);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int phase;
        int k;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // Directed: extremes, every operation, zero against nonzero, both zero, zero divisor.
        for (k = 0; k < 4; k++)
        begin
            add_item(op_t'(k), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            add_item(op_t'(k), 16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
            add_item(op_t'(k), 16'd0, 16'd5, 16'd3, -16'sd7);
            add_item(op_t'(k), 16'd0, 16'd0, 16'd0, 16'd0);
            add_item(op_t'(k), 16'd6, 16'd0, 16'd4, 16'd0);
        end
        add_item(OP_DIV, 16'd9, 16'd12, 16'd0, 16'd3);
        add_item(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        add_item(OP_ADD, -16'sd1, 16'd3, 16'd1, 16'd3);
        add_item(OP_MUL, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
        // Random phases: none, sender idle, receiver stall, both.
        for (phase = 0; phase < 4; phase++)
        begin
            wait (pending_items.size() == 0);
            send_idle_pct = (phase == 1) ? 56 : (phase == 3) ? 17 : 0;
            recv_stall_pct = (phase == 2) ? 56 : (phase == 3) ? 17 : 0;
            for (k = 0; k < 350; k++)
                add_item(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                         rand_operand(), rand_operand());
        end
        wait (pending_items.size() == 0 && expected_fracs.size() == 0);
        repeat (300) @(posedge clk);
        $display("Checked %0d results over all four operations, operand extremes,",
                 checked);
        $display("zero and 0/0 cases, with sender gaps and receiver stalls.");
        if (errors == 0)
            $display("[rational_arith_unit] OK");
        else
            $display("[rational_arith_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[rational_arith_unit] ERROR");
        $finish;
    end
endmodule
